// ----- src/cfbl_pkg.sv -----
// Shared types and codes for the chained free block list.
`default_nettype none

package cfbl_pkg;

   localparam int WORD_WIDTH      = 32;
   localparam int INDEX_WIDTH     = 6;
   localparam int CSR_INDEX_WIDTH = 4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_DATA_BLOCK = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MEDIA_WRITABLE   = 4'd1;

   typedef enum logic [1:0] {
      MODE_FREE,
      MODE_ALLOC,
      MODE_FILL,
      MODE_READ_FAIL
   } mode_type;

   typedef enum logic [2:0] {
      KIND_FREED,
      KIND_GRANTED,
      KIND_EMPTY,
      KIND_SPILL,
      KIND_READ_REQ,
      KIND_REFUSED,
      KIND_FAILED,
      KIND_BUSY
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP_START,
      ST_POP,
      ST_SPILL
   } state_type;

endpackage

`default_nettype wire

// ----- src/cfbl_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none

module cfbl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 50
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/chained_free_block_list.sv -----
// Top level: free block stack sequencer around the stack RAM.
//
// Input channel req_* (valid/ready) carries one command per transfer: free a
// block, allocate, a fill word of a read-back list block, or a read failure.
// Result channel rsp_* (valid/ready) returns the results of each command;
// rsp_last marks the final one. csr_* is a plain write port for
// first_data_block (index 0) and media_writable (index 1).
// An allocate skips popped zero entries above the bottom one; the last fill word
// of a read-back of block zero retries the allocation on the reloaded stack. A
// free into a full stack streams SLOTS+2 results, one per cycle while the receiver
// takes them: a head word of value SLOTS, the SLOTS entries read from the RAM, then
// the freed result.
// One command is in work at a time; req_ready is high only while no command
// is in work, so commands are never taken back to back. Results pass
// through an output register, so a new command is taken while a result waits.
// When the receiver stalls, the sequencer holds until the output register frees.
// Synchronous reset empties the stack, clears all counts and marks, sets
// first_data_block to 0 and media_writable to 1. Stack contents need no
// clearing: no entry is read before it has been written.
`default_nettype none

module chained_free_block_list #(
   parameter int SLOTS = 50
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [1:0]                            req_mode,
   input  wire logic [cfbl_pkg::WORD_WIDTH-1:0]       req_block_number,
   input  wire logic [cfbl_pkg::WORD_WIDTH-1:0]       req_fill_word,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [2:0]                                 rsp_kind,
   output logic [cfbl_pkg::WORD_WIDTH-1:0]            rsp_result_block,
   output logic [cfbl_pkg::INDEX_WIDTH-1:0]           rsp_word_index,
   output logic [cfbl_pkg::WORD_WIDTH-1:0]            rsp_word_value,
   output logic [cfbl_pkg::WORD_WIDTH-1:0]            rsp_total_free,
   output logic                                       rsp_list_dirty,
   output logic                                       rsp_media_modified,
   output logic                                       rsp_last,
   input  wire logic                                  csr_write_enable,
   input  wire logic [cfbl_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [cfbl_pkg::WORD_WIDTH-1:0]       csr_write_data
);

   localparam int AW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int W  = cfbl_pkg::WORD_WIDTH;
   localparam int IW = cfbl_pkg::INDEX_WIDTH;

   cfbl_pkg::state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [W-1:0]   total_ff, total_in;
   logic           dirty_ff, dirty_in;
   logic           modified_ff, modified_in;
   logic           pending_ff, pending_in;
   logic [CW-1:0]  position_ff, position_in;
   logic [W-1:0]   pending_block_ff, pending_block_in;
   logic [AW-1:0]  spill_idx_ff, spill_idx_in;
   logic [W-1:0]   first_data_ff, first_data_in;
   logic           writable_ff, writable_in;

   cfbl_pkg::mode_type mode_ff, mode_in;
   logic [W-1:0]   block_ff, block_in;
   logic [W-1:0]   word_ff, word_in;

   logic           rsp_valid_ff, rsp_valid_in;
   cfbl_pkg::kind_type kind_ff, kind_in;
   logic [W-1:0]   result_block_ff, result_block_in;
   logic [IW-1:0]  word_index_ff, word_index_in;
   logic [W-1:0]   word_value_ff, word_value_in;
   logic [W-1:0]   total_free_ff, total_free_in;
   logic           list_dirty_ff, list_dirty_in;
   logic           media_modified_ff, media_modified_in;
   logic           last_ff, last_in;

   logic           ram_we;
   logic [AW-1:0]  ram_waddr;
   logic [W-1:0]   ram_wdata;
   logic           ram_re;
   logic [AW-1:0]  ram_raddr;
   logic [W-1:0]   ram_rdata;

   cfbl_ram #(
      .WIDTH (W),
      .DEPTH (SLOTS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= cfbl_pkg::ST_IDLE;
         count_ff         <= '0;
         total_ff         <= '0;
         dirty_ff         <= 1'b0;
         modified_ff      <= 1'b0;
         pending_ff       <= 1'b0;
         position_ff      <= '0;
         pending_block_ff <= '0;
         spill_idx_ff     <= '0;
         first_data_ff    <= '0;
         writable_ff      <= 1'b1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         count_ff         <= count_in;
         total_ff         <= total_in;
         dirty_ff         <= dirty_in;
         modified_ff      <= modified_in;
         pending_ff       <= pending_in;
         position_ff      <= position_in;
         pending_block_ff <= pending_block_in;
         spill_idx_ff     <= spill_idx_in;
         first_data_ff    <= first_data_in;
         writable_ff      <= writable_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff           <= mode_in;
      block_ff          <= block_in;
      word_ff           <= word_in;
      kind_ff           <= kind_in;
      result_block_ff   <= result_block_in;
      word_index_ff     <= word_index_in;
      word_value_ff     <= word_value_in;
      total_free_ff     <= total_free_in;
      list_dirty_ff     <= list_dirty_in;
      media_modified_ff <= media_modified_in;
      last_ff           <= last_in;
   end

   always_comb begin
      logic               out_free;
      logic               emit;
      logic               pop_issue;
      cfbl_pkg::kind_type e_kind;
      logic [W-1:0]       e_block;
      logic [IW-1:0]      e_index;
      logic [W-1:0]       e_value;
      logic               e_last;

      state_in         = state_ff;
      count_in         = count_ff;
      total_in         = total_ff;
      dirty_in         = dirty_ff;
      modified_in      = modified_ff;
      pending_in       = pending_ff;
      position_in      = position_ff;
      pending_block_in = pending_block_ff;
      spill_idx_in     = spill_idx_ff;
      first_data_in    = first_data_ff;
      writable_in      = writable_ff;
      mode_in          = mode_ff;
      block_in         = block_ff;
      word_in          = word_ff;

      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = '0;

      out_free  = !rsp_valid_ff || rsp_ready;
      emit      = 1'b0;
      pop_issue = 1'b0;
      e_kind    = cfbl_pkg::KIND_FREED;
      e_block   = '0;
      e_index   = '0;
      e_value   = '0;
      e_last    = 1'b1;

      req_ready = (state_ff == cfbl_pkg::ST_IDLE);

      if (csr_write_enable) begin
         if (csr_index == cfbl_pkg::CSR_FIRST_DATA_BLOCK) begin
            first_data_in = csr_write_data;
         end
         if (csr_index == cfbl_pkg::CSR_MEDIA_WRITABLE) begin
            writable_in = csr_write_data[0];
         end
      end

      case (state_ff)
         cfbl_pkg::ST_IDLE: begin
            if (req_valid) begin
               mode_in  = cfbl_pkg::mode_type'(req_mode);
               block_in = req_block_number;
               word_in  = req_fill_word;
               if (req_mode == cfbl_pkg::MODE_ALLOC && !pending_ff && count_ff != '0) begin
                  pop_issue = 1'b1;
                  state_in  = cfbl_pkg::ST_POP;
               end else begin
                  state_in = cfbl_pkg::ST_EXEC;
               end
            end
         end
         cfbl_pkg::ST_EXEC: begin
            case (mode_ff)
               cfbl_pkg::MODE_FREE, cfbl_pkg::MODE_ALLOC: begin
                  if (pending_ff) begin
                     if (out_free) begin
                        emit     = 1'b1;
                        e_kind   = cfbl_pkg::KIND_BUSY;
                        e_block  = pending_block_ff;
                        state_in = cfbl_pkg::ST_IDLE;
                     end
                  end else if (mode_ff == cfbl_pkg::MODE_ALLOC) begin
                     state_in = cfbl_pkg::ST_POP_START;
                  end else if (count_ff >= CW'(SLOTS)) begin
                     if (out_free) begin
                        emit    = 1'b1;
                        e_block = block_ff;
                        if (!writable_ff || block_ff < first_data_ff) begin
                           e_kind   = cfbl_pkg::KIND_REFUSED;
                           state_in = cfbl_pkg::ST_IDLE;
                        end else begin
                           e_kind       = cfbl_pkg::KIND_SPILL;
                           e_value      = W'(SLOTS);
                           e_last       = 1'b0;
                           modified_in  = 1'b1;
                           ram_re       = 1'b1;
                           ram_raddr    = '0;
                           spill_idx_in = '0;
                           state_in     = cfbl_pkg::ST_SPILL;
                        end
                     end
                  end else if (out_free) begin
                     ram_we    = 1'b1;
                     ram_waddr = AW'(count_ff);
                     ram_wdata = block_ff;
                     count_in  = count_ff + 1'b1;
                     dirty_in  = 1'b1;
                     if (block_ff != '0 && total_ff != '1) begin
                        total_in = total_ff + 1'b1;
                     end
                     emit     = 1'b1;
                     e_kind   = cfbl_pkg::KIND_FREED;
                     e_block  = block_ff;
                     state_in = cfbl_pkg::ST_IDLE;
                  end
               end
               cfbl_pkg::MODE_FILL: begin
                  if (!pending_ff) begin
                     state_in = cfbl_pkg::ST_IDLE;
                  end else if (position_ff != CW'(SLOTS)) begin
                     if (position_ff == '0) begin
                        count_in = (word_ff > W'(SLOTS)) ? CW'(SLOTS) : CW'(word_ff);
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(position_ff - 1'b1);
                        ram_wdata = word_ff;
                     end
                     position_in = position_ff + 1'b1;
                     state_in    = cfbl_pkg::ST_IDLE;
                  end else if (pending_block_ff == '0 || out_free) begin
                     ram_we      = 1'b1;
                     ram_waddr   = AW'(position_ff - 1'b1);
                     ram_wdata   = word_ff;
                     pending_in  = 1'b0;
                     position_in = '0;
                     if (pending_block_ff != '0) begin
                        emit     = 1'b1;
                        e_kind   = cfbl_pkg::KIND_GRANTED;
                        e_block  = pending_block_ff;
                        state_in = cfbl_pkg::ST_IDLE;
                     end else begin
                        state_in = cfbl_pkg::ST_POP_START;
                     end
                  end
               end
               cfbl_pkg::MODE_READ_FAIL: begin
                  if (!pending_ff) begin
                     state_in = cfbl_pkg::ST_IDLE;
                  end else if (out_free) begin
                     pending_in  = 1'b0;
                     position_in = '0;
                     count_in    = '0;
                     emit        = 1'b1;
                     e_kind      = cfbl_pkg::KIND_FAILED;
                     e_block     = pending_block_ff;
                     state_in    = cfbl_pkg::ST_IDLE;
                  end
               end
               default: begin
                  state_in = cfbl_pkg::ST_IDLE;
               end
            endcase
         end
         cfbl_pkg::ST_POP_START: begin
            if (count_ff != '0) begin
               pop_issue = 1'b1;
               state_in  = cfbl_pkg::ST_POP;
            end else if (out_free) begin
               emit     = 1'b1;
               e_kind   = cfbl_pkg::KIND_EMPTY;
               state_in = cfbl_pkg::ST_IDLE;
            end
         end
         cfbl_pkg::ST_POP: begin
            if (count_ff == '0) begin
               if (out_free) begin
                  emit    = 1'b1;
                  e_block = ram_rdata;
                  if (ram_rdata < first_data_ff) begin
                     e_kind = cfbl_pkg::KIND_FAILED;
                  end else begin
                     e_kind           = cfbl_pkg::KIND_READ_REQ;
                     pending_in       = 1'b1;
                     position_in      = '0;
                     pending_block_in = ram_rdata;
                  end
                  state_in = cfbl_pkg::ST_IDLE;
               end
            end else if (ram_rdata != '0) begin
               if (out_free) begin
                  emit     = 1'b1;
                  e_kind   = cfbl_pkg::KIND_GRANTED;
                  e_block  = ram_rdata;
                  state_in = cfbl_pkg::ST_IDLE;
               end
            end else begin
               // zero entry: skip and pop the next one
               pop_issue = 1'b1;
            end
         end
         cfbl_pkg::ST_SPILL: begin
            if (out_free) begin
               emit    = 1'b1;
               e_kind  = cfbl_pkg::KIND_SPILL;
               e_block = block_ff;
               e_index = IW'(spill_idx_ff) + 1'b1;
               e_value = ram_rdata;
               e_last  = 1'b0;
               if (spill_idx_ff == AW'(SLOTS - 1)) begin
                  count_in = '0;
                  state_in = cfbl_pkg::ST_EXEC;
               end else begin
                  ram_re       = 1'b1;
                  ram_raddr    = spill_idx_ff + 1'b1;
                  spill_idx_in = spill_idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = cfbl_pkg::ST_IDLE;
         end
      endcase

      if (pop_issue) begin
         ram_re    = 1'b1;
         ram_raddr = AW'(count_ff - 1'b1);
         count_in  = count_ff - 1'b1;
         dirty_in  = 1'b1;
         if (total_ff != '0) begin
            total_in = total_ff - 1'b1;
         end
      end

      rsp_valid_in      = emit || (rsp_valid_ff && !rsp_ready);
      kind_in           = emit ? e_kind : kind_ff;
      result_block_in   = emit ? e_block : result_block_ff;
      word_index_in     = emit ? e_index : word_index_ff;
      word_value_in     = emit ? e_value : word_value_ff;
      total_free_in     = emit ? total_in : total_free_ff;
      list_dirty_in     = emit ? dirty_in : list_dirty_ff;
      media_modified_in = emit ? modified_in : media_modified_ff;
      last_in           = emit ? e_last : last_ff;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_result_block   = result_block_ff;
   assign rsp_word_index     = word_index_ff;
   assign rsp_word_value     = word_value_ff;
   assign rsp_total_free     = total_free_ff;
   assign rsp_list_dirty     = list_dirty_ff;
   assign rsp_media_modified = media_modified_ff;
   assign rsp_last           = last_ff;

endmodule

`default_nettype wire

// ----- src/cfbl_checker.sv -----
// Port-level checks on the free block list, bound to the top level.
`default_nettype none

module cfbl_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_kind,
   input wire logic        rsp_media_modified,
   input wire logic        rsp_last
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one command in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second command taken while one is in work");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == cfbl_pkg::KIND_SPILL |-> !rsp_last && rsp_media_modified)
      else $error("spill word marked last or media not marked");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == cfbl_pkg::KIND_BUSY || rsp_kind == cfbl_pkg::KIND_FREED ||
                    rsp_kind == cfbl_pkg::KIND_GRANTED) |-> rsp_last)
      else $error("single result not marked last");

endmodule

bind chained_free_block_list cfbl_checker u_cfbl_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for chained_free_block_list: directed and random commands checked by a local predictor.
`timescale 1ns / 1ps

module tb;

   localparam int SLOTS     = 50;
   localparam int RUN_LIMIT = 400000;
   localparam int SETTLE    = 20;
   localparam int LONG_HOLD = 400;

   typedef struct packed {
      cfbl_pkg::mode_type mode;
      logic [31:0]        block_number;
      logic [31:0]        fill_word;
   } list_command_type;

   typedef struct packed {
      cfbl_pkg::kind_type kind;
      logic [31:0]        result_block;
      logic [5:0]         word_index;
      logic [31:0]        word_value;
      logic [31:0]        total_free;
      logic               list_dirty;
      logic               media_modified;
      logic               last;
   } list_result_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic [1:0]                           req_mode = '0;
   logic [cfbl_pkg::WORD_WIDTH-1:0]      req_block_number = '0;
   logic [cfbl_pkg::WORD_WIDTH-1:0]      req_fill_word = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic [2:0]                           rsp_kind;
   logic [cfbl_pkg::WORD_WIDTH-1:0]      rsp_result_block;
   logic [cfbl_pkg::INDEX_WIDTH-1:0]     rsp_word_index;
   logic [cfbl_pkg::WORD_WIDTH-1:0]      rsp_word_value;
   logic [cfbl_pkg::WORD_WIDTH-1:0]      rsp_total_free;
   logic                                 rsp_list_dirty;
   logic                                 rsp_media_modified;
   logic                                 rsp_last;
   logic                                 csr_write_enable = 1'b0;
   logic [cfbl_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [cfbl_pkg::WORD_WIDTH-1:0]      csr_write_data = '0;

   // predicted block state
   logic [31:0] stack_mem [SLOTS] = '{default: '0};
   int          stack_depth = 0;
   logic [31:0] free_count = '0;
   logic        dirty_flag = 1'b0;
   logic        modified_flag = 1'b0;
   logic        reload_active = 1'b0;
   int          reload_pos = 0;
   logic [31:0] reload_block = '0;
   logic [31:0] data_start = '0;
   logic        writable = 1'b1;

   list_command_type command_q [$];
   list_command_type offered;
   list_result_type  awaited_results [$];
   list_result_type  step_results [$];
   list_result_type  oldest;

   int queued_count = 0;
   int accepted_count = 0;
   int error_count = 0;
   int cycle_count = 0;
   int hold_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   logic long_hold = 1'b0;
   bit growing = 1'b1;

   chained_free_block_list #(
      .SLOTS(SLOTS)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_block_number   (req_block_number),
      .req_fill_word      (req_fill_word),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_result_block   (rsp_result_block),
      .rsp_word_index     (rsp_word_index),
      .rsp_word_value     (rsp_word_value),
      .rsp_total_free     (rsp_total_free),
      .rsp_list_dirty     (rsp_list_dirty),
      .rsp_media_modified (rsp_media_modified),
      .rsp_last           (rsp_last),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void note_result(cfbl_pkg::kind_type kind, logic [31:0] blk,
                                       logic [5:0] idx, logic [31:0] val);
      list_result_type r;
      r.kind           = kind;
      r.result_block   = blk;
      r.word_index     = idx;
      r.word_value     = val;
      r.total_free     = free_count;
      r.list_dirty     = dirty_flag;
      r.media_modified = modified_flag;
      r.last           = 1'b0;
      step_results.push_back(r);
   endfunction

   // pops until a grant, an empty list, a reload request or a failed one; zero entries above the bottom are skipped
   function automatic void pop_entry();
      logic [31:0] blk;
      bit done;
      done = 1'b0;
      while (!done) begin
         if (stack_depth == 0) begin
            note_result(cfbl_pkg::KIND_EMPTY, '0, '0, '0);
            done = 1'b1;
         end else begin
            stack_depth--;
            if (free_count != 0) free_count--;
            blk = stack_mem[stack_depth];
            stack_mem[stack_depth] = '0;
            dirty_flag = 1'b1;
            if (stack_depth == 0) begin
               if (blk < data_start) begin
                  note_result(cfbl_pkg::KIND_FAILED, blk, '0, '0);
               end else begin
                  reload_active = 1'b1;
                  reload_pos = 0;
                  reload_block = blk;
                  note_result(cfbl_pkg::KIND_READ_REQ, blk, '0, '0);
               end
               done = 1'b1;
            end else if (blk != 0) begin
               note_result(cfbl_pkg::KIND_GRANTED, blk, '0, '0);
               done = 1'b1;
            end
         end
      end
   endfunction

   function automatic void track_command(list_command_type cmd);
      list_result_type final_one;
      int i;
      step_results.delete();
      case (cmd.mode)
         cfbl_pkg::MODE_FREE, cfbl_pkg::MODE_ALLOC: begin
            if (reload_active) begin
               note_result(cfbl_pkg::KIND_BUSY, reload_block, '0, '0);
            end else if (cmd.mode == cfbl_pkg::MODE_ALLOC) begin
               pop_entry();
            end else if (stack_depth >= SLOTS &&
                         (!writable || cmd.block_number < data_start)) begin
               note_result(cfbl_pkg::KIND_REFUSED, cmd.block_number, '0, '0);
            end else begin
               if (stack_depth >= SLOTS) begin
                  modified_flag = 1'b1;
                  note_result(cfbl_pkg::KIND_SPILL, cmd.block_number, '0, SLOTS);
                  for (i = 0; i < SLOTS; i++)
                     note_result(cfbl_pkg::KIND_SPILL, cmd.block_number, 6'(i + 1),
                                 stack_mem[i]);
                  stack_depth = 0;
               end
               stack_mem[stack_depth] = cmd.block_number;
               stack_depth++;
               dirty_flag = 1'b1;
               if (cmd.block_number != 0 && free_count != 32'hFFFF_FFFF) free_count++;
               note_result(cfbl_pkg::KIND_FREED, cmd.block_number, '0, '0);
            end
         end
         cfbl_pkg::MODE_FILL: begin
            if (reload_active) begin
               if (reload_pos == 0)
                  stack_depth = (cmd.fill_word > SLOTS) ? SLOTS : int'(cmd.fill_word);
               else
                  stack_mem[reload_pos - 1] = cmd.fill_word;
               reload_pos++;
               if (reload_pos > SLOTS) begin
                  reload_active = 1'b0;
                  reload_pos = 0;
                  if (reload_block != 0)
                     note_result(cfbl_pkg::KIND_GRANTED, reload_block, '0, '0);
                  else pop_entry();
               end
            end
         end
         cfbl_pkg::MODE_READ_FAIL: begin
            if (reload_active) begin
               reload_active = 1'b0;
               reload_pos = 0;
               stack_depth = 0;
               note_result(cfbl_pkg::KIND_FAILED, reload_block, '0, '0);
            end
         end
         default: begin
         end
      endcase
      if (step_results.size() != 0) begin
         final_one = step_results.pop_back();
         final_one.last = 1'b1;
         step_results.push_back(final_one);
      end
      foreach (step_results[k]) awaited_results.push_back(step_results[k]);
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      end
   endfunction

   // input side
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            track_command(offered);
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (command_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered = command_q.pop_front();
               req_valid <= 1'b1;
               req_mode <= offered.mode;
               req_block_number <= offered.block_number;
               req_fill_word <= offered.fill_word;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (long_hold && hold_count < LONG_HOLD) begin
         hold_count++;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected transfer: kind %0d block %h", $time, rsp_kind,
                     rsp_result_block);
         end else begin
            oldest = awaited_results.pop_front();
            check_field("kind", oldest.kind, rsp_kind);
            check_field("result_block", oldest.result_block, rsp_result_block);
            check_field("word_index", oldest.word_index, rsp_word_index);
            check_field("word_value", oldest.word_value, rsp_word_value);
            check_field("total_free", oldest.total_free, rsp_total_free);
            check_field("list_dirty", oldest.list_dirty, rsp_list_dirty);
            check_field("media_modified", oldest.media_modified, rsp_media_modified);
            check_field("last", oldest.last, rsp_last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic void queue_command(cfbl_pkg::mode_type mode, logic [31:0] bno,
                                         logic [31:0] word);
      list_command_type c;
      c.mode = mode;
      c.block_number = bno;
      c.fill_word = word;
      command_q.push_back(c);
      queued_count++;
   endfunction

   function automatic logic [31:0] pick_block();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return '0;
      if (roll < 22) return 32'($urandom_range(2000));
      if (roll < 27) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   // rest of a list block read-back, with the odd busy command and optional read failure
   function automatic int plan_fill(bit may_fail);
      int stop_at;
      int count;
      int pos;
      int roll;
      logic [31:0] word;
      count = 0;
      stop_at = SLOTS + 1;
      if (may_fail && $urandom_range(99) < 15) stop_at = $urandom_range(reload_pos, SLOTS);
      for (pos = reload_pos; pos <= SLOTS; pos++) begin
         if ($urandom_range(99) < 3) begin
            queue_command($urandom_range(1) ? cfbl_pkg::MODE_FREE : cfbl_pkg::MODE_ALLOC,
                          pick_block(), $urandom);
            count++;
         end
         if (pos == stop_at) begin
            queue_command(cfbl_pkg::MODE_READ_FAIL, $urandom, $urandom);
            return count + 1;
         end
         roll = $urandom_range(99);
         if (pos == 0) begin
            if (roll < 15) word = '0;
            else if (roll < 22) word = 32'hFFFF_FFFF;
            else if (roll < 30) word = $urandom;
            else if (roll < 40) word = SLOTS;
            else word = 32'($urandom_range(1, SLOTS));
         end else begin
            word = pick_block();
         end
         queue_command(cfbl_pkg::MODE_FILL, $urandom, word);
         count++;
      end
      return count;
   endfunction

   task automatic wait_sent();
      do @(posedge clock); while (accepted_count != queued_count);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (accepted_count != queued_count || awaited_results.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [cfbl_pkg::CSR_INDEX_WIDTH-1:0] index, logic [31:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      if (index == cfbl_pkg::CSR_FIRST_DATA_BLOCK) data_start = data;
      else if (index == cfbl_pkg::CSR_MEDIA_WRITABLE) writable = data[0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_phase(logic [31:0] start, logic wr, int send_pct, int rcv_pct);
      write_csr(cfbl_pkg::CSR_FIRST_DATA_BLOCK, start);
      write_csr(cfbl_pkg::CSR_MEDIA_WRITABLE, {31'($urandom), wr});
      send_idle_pct <= send_pct;
      stall_pct <= rcv_pct;
   endtask

   // random walk: grow to a spill, drain to a reload, with some noise
   task automatic run_phase(int quota);
      int planned;
      int n;
      int i;
      planned = 0;
      while (planned < quota) begin
         wait_sent();
         if (reload_active) begin
            planned += plan_fill(1'b1);
         end else if ($urandom_range(99) < 12) begin
            n = $urandom_range(3, 6);
            for (i = 0; i < n; i++)
               queue_command(cfbl_pkg::mode_type'($urandom_range(3)), pick_block(), $urandom);
            planned += n;
         end else if (growing) begin
            if (stack_depth >= SLOTS) begin
               n = $urandom_range(1, 2);
               if ($urandom_range(99) < 70) growing = 1'b0;
            end else begin
               n = $urandom_range(4, 16);
               if (n > SLOTS - stack_depth) n = SLOTS - stack_depth;
               if ($urandom_range(99) < 5) growing = 1'b0;
            end
            for (i = 0; i < n; i++) queue_command(cfbl_pkg::MODE_FREE, pick_block(), $urandom);
            planned += n;
         end else begin
            if (stack_depth == 0) begin
               n = 1;
               growing = 1'b1;
            end else begin
               n = $urandom_range(3, 16);
               if (n > stack_depth + 1) n = stack_depth + 1;
               if ($urandom_range(99) < 8) growing = 1'b1;
            end
            for (i = 0; i < n; i++) queue_command(cfbl_pkg::MODE_ALLOC, $urandom, $urandom);
            planned += n;
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      queue_command(cfbl_pkg::MODE_ALLOC, '0, '0);
      queue_command(cfbl_pkg::MODE_FILL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_command(cfbl_pkg::MODE_READ_FAIL, '0, '0);
      queue_command(cfbl_pkg::MODE_FREE, 32'hFFFF_FFFF, '0);
      queue_command(cfbl_pkg::MODE_FREE, '0, 32'hFFFF_FFFF);
      queue_command(cfbl_pkg::MODE_FREE, '0, '0);
      queue_command(cfbl_pkg::MODE_FREE, 32'h0000_0001, '0);
      queue_command(cfbl_pkg::MODE_ALLOC, '0, '0);
      // skips two zero entries, then runs empty and asks for a read-back
      queue_command(cfbl_pkg::MODE_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_command(cfbl_pkg::MODE_FREE, 32'h1234_5678, '0);
      queue_command(cfbl_pkg::MODE_ALLOC, '0, '0);
      queue_command(cfbl_pkg::MODE_FILL, '0, 32'd50);
      queue_command(cfbl_pkg::MODE_READ_FAIL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_command(cfbl_pkg::MODE_FREE, 32'hAAAA_AAAA, 32'h5555_5555);
      queue_command(cfbl_pkg::MODE_FREE, 32'h5555_5555, 32'hAAAA_AAAA);
      queue_command(cfbl_pkg::MODE_ALLOC, '0, '0);
      queue_command(cfbl_pkg::MODE_ALLOC, '0, '0);
      queue_command(cfbl_pkg::MODE_READ_FAIL, '0, '0);
      queue_command(cfbl_pkg::MODE_ALLOC, '0, '0);
      wait_drained();

      set_phase(32'h0, 1'b1, 0, 0);
      // read-back of block zero: the allocation retries on the reloaded stack
      queue_command(cfbl_pkg::MODE_FREE, '0, $urandom);
      queue_command(cfbl_pkg::MODE_ALLOC, $urandom, $urandom);
      wait_sent();
      // a full reload, so that a spill follows soon
      queue_command(cfbl_pkg::MODE_FILL, $urandom, SLOTS);
      wait_sent();
      void'(plan_fill(1'b0));
      run_phase(12);
      wait_drained();

      set_phase(32'd1000, 1'b1, 46, 0);
      run_phase(12);
      wait_drained();

      set_phase(32'hFFFF_FFFF, 1'b1, 0, 46);
      run_phase(12);
      wait_drained();

      set_phase(32'h8000_0000, 1'b0, 19, 19);
      run_phase(12);
      wait_drained();

      set_phase(32'h0, 1'b1, 0, 0);
      long_hold <= 1'b1;
      run_phase(12);
      wait_drained();

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- chained_free_block_list.f -----
src/cfbl_pkg.sv
src/cfbl_ram.sv
src/chained_free_block_list.sv
src/cfbl_checker.sv
tb/tb.sv
